@@ rtl/core/ofr_pkg.sv @@
package ofr_pkg;

  // Internal unit vectors carry this many fractional bits
  localparam int INT_FRAC = 29;
  // Signed width of a unit vector component (magnitude up to 2^INT_FRAC)
  localparam int UW = INT_FRAC + 2;
  // Magnitude width after block normalization, top in [2^29, 2^30)
  localparam int NB = INT_FRAC + 1;
  // Root width of the sum of three squares
  localparam int RB = NB + 1;
  // Width of the sum of three squares
  localparam int N2W = 2 * NB + 2;
  // Quotient bits of one normalizing division
  localparam int QB = NB;
  // Width of an intermediate signed vector component
  localparam int VW_MID = 32;
  // Width of one result field
  localparam int OUT_W = 16;

  typedef logic [2:0][UW-1:0] uvec_t;

  typedef struct packed {
    uvec_t u;
    uvec_t f;
    logic  ok;
  } ctx_t;

  typedef struct packed {
    logic valid;
    logic ok;
  } nst_t;

  // Arithmetic shift right by a constant, rounding half away from zero
  function automatic logic signed [63:0] shr_round(input logic signed [63:0] v,
                                                   input int unsigned s);
    logic [63:0] m;
    if (s == 0) return v;
    m = v[63] ? (~v + 64'd1) : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? (~m + 64'd1) : m;
  endfunction

endpackage

@@ rtl/core/ofr_norm.sv @@
module ofr_norm
  import ofr_pkg::*;
#(
  parameter int VW  = 16,
  parameter int SBW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2:0][VW-1:0]  vin,
  input  logic [SBW-1:0]      sb_in,
  output nst_t                st,
  output uvec_t               uout,
  output logic [SBW-1:0]      sb_out
);

  localparam int SW  = (VW > NB) ? VW : NB;
  localparam int NSH = 10;
  localparam int RW  = RB + 2;
  localparam int DXW = 2 * NB + 1;
  localparam int DW  = RB + 1;

  // Magnitudes and largest magnitude of the incoming vector
  logic [2:0][SW-1:0] mag_c;
  logic [SW-1:0]      top_c;

  always_comb begin
    logic [VW-1:0] t;
    t = '0;
    for (int i = 0; i < 3; i++) begin
      t = vin[i][VW-1] ? (~vin[i] + 1'b1) : vin[i];
      mag_c[i] = SW'(t);
    end
    top_c = mag_c[0];
    if (mag_c[1] > top_c) top_c = mag_c[1];
    if (mag_c[2] > top_c) top_c = mag_c[2];
  end

  // Block shift stages
  logic               sh_v_r  [0:NSH];
  logic               sh_z_r  [0:NSH];
  logic [2:0]         sh_n_r  [0:NSH];
  logic [2:0][SW-1:0] sh_a_r  [0:NSH];
  logic [SW-1:0]      sh_t_r  [0:NSH];
  logic [SBW-1:0]     sh_sb_r [0:NSH];

  always_ff @(posedge clk) begin
    if (!rst_n) sh_v_r[0] <= 1'b0;
    else if (en) sh_v_r[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sh_z_r[0]  <= (top_c == '0);
      sh_a_r[0]  <= mag_c;
      sh_t_r[0]  <= top_c;
      sh_sb_r[0] <= sb_in;
      for (int i = 0; i < 3; i++) sh_n_r[0][i] <= vin[i][VW-1];
    end
  end

  for (genvar k = 1; k <= NSH; k++) begin : g_shift
    localparam bit RIGHT = (k <= 5);
    localparam int S = RIGHT ? (32 >> k) : (32 >> (k - 5));
    logic do_c;

    // Shift down while the top is too large, then up while too small
    assign do_c = RIGHT ? (64'(sh_t_r[k-1]) >= (64'd1 << (NB - 1 + S)))
                        : (64'(sh_t_r[k-1]) < (64'd1 << (NB - S)));

    always_ff @(posedge clk) begin
      if (!rst_n) sh_v_r[k] <= 1'b0;
      else if (en) sh_v_r[k] <= sh_v_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sh_z_r[k]  <= sh_z_r[k-1];
        sh_n_r[k]  <= sh_n_r[k-1];
        sh_sb_r[k] <= sh_sb_r[k-1];
        for (int i = 0; i < 3; i++) begin
          if (!do_c) sh_a_r[k][i] <= sh_a_r[k-1][i];
          else if (RIGHT) sh_a_r[k][i] <= sh_a_r[k-1][i] >> S;
          else sh_a_r[k][i] <= sh_a_r[k-1][i] << S;
        end
        if (!do_c) sh_t_r[k] <= sh_t_r[k-1];
        else if (RIGHT) sh_t_r[k] <= sh_t_r[k-1] >> S;
        else sh_t_r[k] <= sh_t_r[k-1] << S;
      end
    end
  end

  // Squares
  logic                 sq_v_r;
  logic                 sq_z_r;
  logic [2:0]           sq_n_r;
  logic [2:0][NB-1:0]   sq_a_r;
  logic [2:0][2*NB-1:0] sq_p_r;
  logic [SBW-1:0]       sq_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r <= 1'b0;
    else if (en) sq_v_r <= sh_v_r[NSH];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_z_r  <= sh_z_r[NSH];
      sq_n_r  <= sh_n_r[NSH];
      sq_sb_r <= sh_sb_r[NSH];
      for (int i = 0; i < 3; i++) begin
        sq_a_r[i] <= sh_a_r[NSH][i][NB-1:0];
        sq_p_r[i] <= sh_a_r[NSH][i][NB-1:0] * sh_a_r[NSH][i][NB-1:0];
      end
    end
  end

  // Square root, one result bit per stage; stage zero sums the squares
  logic               rt_v_r    [0:RB];
  logic               rt_z_r    [0:RB];
  logic [2:0]         rt_n_r    [0:RB];
  logic [2:0][NB-1:0] rt_a_r    [0:RB];
  logic [N2W-1:0]     rt_x_r    [0:RB];
  logic [RW-1:0]      rt_rem_r  [0:RB];
  logic [RB-1:0]      rt_root_r [0:RB];
  logic [SBW-1:0]     rt_sb_r   [0:RB];

  always_ff @(posedge clk) begin
    if (!rst_n) rt_v_r[0] <= 1'b0;
    else if (en) rt_v_r[0] <= sq_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rt_z_r[0]    <= sq_z_r;
      rt_n_r[0]    <= sq_n_r;
      rt_a_r[0]    <= sq_a_r;
      rt_sb_r[0]   <= sq_sb_r;
      rt_x_r[0]    <= N2W'(sq_p_r[0]) + N2W'(sq_p_r[1]) + N2W'(sq_p_r[2]);
      rt_rem_r[0]  <= '0;
      rt_root_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= RB; k++) begin : g_sqrt
    localparam int P = RB - k;
    logic [RW+1:0] tmp_c;
    logic [RW+1:0] trial_c;
    logic          ge_c;

    assign tmp_c   = {rt_rem_r[k-1], rt_x_r[k-1][2*P+1 -: 2]};
    assign trial_c = (RW + 2)'({rt_root_r[k-1], 2'b01});
    assign ge_c    = (tmp_c >= trial_c);

    always_ff @(posedge clk) begin
      if (!rst_n) rt_v_r[k] <= 1'b0;
      else if (en) rt_v_r[k] <= rt_v_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt_z_r[k]    <= rt_z_r[k-1];
        rt_n_r[k]    <= rt_n_r[k-1];
        rt_a_r[k]    <= rt_a_r[k-1];
        rt_sb_r[k]   <= rt_sb_r[k-1];
        rt_x_r[k]    <= rt_x_r[k-1];
        rt_rem_r[k]  <= ge_c ? RW'(tmp_c - trial_c) : RW'(tmp_c);
        rt_root_r[k] <= {rt_root_r[k-1][RB-2:0], ge_c};
      end
    end
  end

  // Rounded division a * 2^29 / m, one quotient bit per stage
  logic [2:0][DXW-1:0] nx_c;

  always_comb begin
    for (int i = 0; i < 3; i++)
      nx_c[i] = DXW'({rt_a_r[RB][i], {NB{1'b0}}}) + DXW'(rt_root_r[RB]);
  end

  logic                dv_v_r  [0:QB];
  logic                dv_z_r  [0:QB];
  logic [2:0]          dv_n_r  [0:QB];
  logic [2:0][DXW-1:0] dv_x_r  [0:QB];
  logic [DW-1:0]       dv_d_r  [0:QB];
  logic [2:0][DW-1:0]  dv_r_r  [0:QB];
  logic [2:0][QB-1:0]  dv_q_r  [0:QB];
  logic [SBW-1:0]      dv_sb_r [0:QB];

  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (en) dv_v_r[0] <= rt_v_r[RB];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_z_r[0]  <= rt_z_r[RB];
      dv_n_r[0]  <= rt_n_r[RB];
      dv_sb_r[0] <= rt_sb_r[RB];
      dv_x_r[0]  <= nx_c;
      dv_d_r[0]  <= {rt_root_r[RB], 1'b0};
      for (int i = 0; i < 3; i++) begin
        dv_r_r[0][i] <= DW'(nx_c[i][DXW-1:NB]);
        dv_q_r[0][i] <= '0;
      end
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_div
    localparam int B = QB - j;
    logic [2:0][DW:0] tmp_c;
    logic [2:0]       ge_c;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        tmp_c[i] = {dv_r_r[j-1][i], dv_x_r[j-1][i][B]};
        ge_c[i]  = (tmp_c[i] >= {1'b0, dv_d_r[j-1]});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[j] <= 1'b0;
      else if (en) dv_v_r[j] <= dv_v_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_z_r[j]  <= dv_z_r[j-1];
        dv_n_r[j]  <= dv_n_r[j-1];
        dv_sb_r[j] <= dv_sb_r[j-1];
        dv_x_r[j]  <= dv_x_r[j-1];
        dv_d_r[j]  <= dv_d_r[j-1];
        for (int i = 0; i < 3; i++) begin
          dv_r_r[j][i] <= ge_c[i] ? DW'(tmp_c[i] - {1'b0, dv_d_r[j-1]}) : DW'(tmp_c[i]);
          dv_q_r[j][i] <= {dv_q_r[j-1][i][QB-2:0], ge_c[i]};
        end
      end
    end
  end

  // Restore signs
  logic           fo_v_r;
  logic           fo_z_r;
  uvec_t          fo_u_r;
  logic [SBW-1:0] fo_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) fo_v_r <= 1'b0;
    else if (en) fo_v_r <= dv_v_r[QB];
  end

  always_ff @(posedge clk) begin
    logic [UW-1:0] qe;
    if (en) begin
      fo_z_r  <= dv_z_r[QB];
      fo_sb_r <= dv_sb_r[QB];
      for (int i = 0; i < 3; i++) begin
        qe = UW'(dv_q_r[QB][i]);
        fo_u_r[i] <= dv_n_r[QB][i] ? (~qe + 1'b1) : qe;
      end
    end
  end

  assign st.valid = fo_v_r;
  assign st.ok    = !fo_z_r;
  assign uout     = fo_u_r;
  assign sb_out   = fo_sb_r;

endmodule

@@ rtl/core/orthonormal_frame_from_two_vectors.sv @@
// Channel  | Handshake            | Payload
// ---------+----------------------+-----------------------------------------
// in       | in_valid / in_ready  | in_up_x..z, in_fwd_x..z (IN_WIDTH, Q.13)
// out      | out_valid / out_ready| out_valid_res, nine 16-bit entries
//
// One item enters per cycle while the output is not stalled; each item passes
// through four normalizing units of 76 stages (31-stage square root and
// 30-stage divider set the depth) plus 14 product, sum and check stages.
// Synchronous reset clears the valid bits of every stage.
// A stall on the result side freezes the whole pipeline, holding every item.
module orthonormal_frame_from_two_vectors
  import ofr_pkg::*;
#(
  parameter int IN_WIDTH = 16,
  parameter int OUT_FRAC = 14
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [IN_WIDTH-1:0] in_up_x,
  input  logic signed [IN_WIDTH-1:0] in_up_y,
  input  logic signed [IN_WIDTH-1:0] in_up_z,
  input  logic signed [IN_WIDTH-1:0] in_fwd_x,
  input  logic signed [IN_WIDTH-1:0] in_fwd_y,
  input  logic signed [IN_WIDTH-1:0] in_fwd_z,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_valid_res,
  output logic signed [OUT_W-1:0]    out_fx_sx,
  output logic signed [OUT_W-1:0]    out_fx_sy,
  output logic signed [OUT_W-1:0]    out_fx_sz,
  output logic signed [OUT_W-1:0]    out_ly_sx,
  output logic signed [OUT_W-1:0]    out_ly_sy,
  output logic signed [OUT_W-1:0]    out_ly_sz,
  output logic signed [OUT_W-1:0]    out_uz_sx,
  output logic signed [OUT_W-1:0]    out_uz_sy,
  output logic signed [OUT_W-1:0]    out_uz_sz
);

  localparam int DSH = (INT_FRAC >= OUT_FRAC) ? (INT_FRAC - OUT_FRAC) : 0;
  localparam int LSH = (OUT_FRAC > INT_FRAC) ? (OUT_FRAC - INT_FRAC) : 0;
  localparam int USH = 2 * DSH;
  localparam int ESH = 2 * LSH;
  localparam logic [63:0] SHORT_LIM = (LSH == 0) ? (64'd3 << USH)
                                      : ((64'd3 + (64'd1 << ESH) - 64'd1) >> ESH);

  function automatic logic [OUT_W-1:0] to_out(input logic [UW-1:0] v);
    logic signed [63:0] w;
    logic signed [63:0] r;
    w = 64'($signed(v));
    if (LSH == 0) r = shr_round(w, DSH);
    else r = w <<< LSH;
    return r[OUT_W-1:0];
  endfunction

  logic en;
  logic out_valid_r;

  // Advance every stage unless a finished item is held at the output
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Normalize up, carry raw forward
  nst_t                      st_u;
  uvec_t                     u_vec;
  logic [2:0][IN_WIDTH-1:0]  fwd_raw;

  ofr_norm #(.VW(IN_WIDTH), .SBW(3 * IN_WIDTH)) u_norm_up (
    .clk, .rst_n, .en,
    .in_valid (in_valid),
    .vin      ({in_up_z, in_up_y, in_up_x}),
    .sb_in    ({in_fwd_z, in_fwd_y, in_fwd_x}),
    .st       (st_u),
    .uout     (u_vec),
    .sb_out   (fwd_raw)
  );

  // Normalize forward
  ctx_t  ctx_fi;
  ctx_t  ctx_fo;
  nst_t  st_f;
  uvec_t f_vec;

  always_comb begin
    ctx_fi    = '0;
    ctx_fi.u  = u_vec;
    ctx_fi.ok = st_u.ok;
  end

  ofr_norm #(.VW(IN_WIDTH), .SBW($bits(ctx_t))) u_norm_fwd (
    .clk, .rst_n, .en,
    .in_valid (st_u.valid),
    .vin      (fwd_raw),
    .sb_in    (ctx_fi),
    .st       (st_f),
    .uout     (f_vec),
    .sb_out   (ctx_fo)
  );

  // Dot product u.f
  logic               d1_v_r;
  ctx_t               d1_c_r;
  logic signed [63:0] d1_p_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) d1_v_r <= 1'b0;
    else if (en) d1_v_r <= st_f.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_c_r.u  <= ctx_fo.u;
      d1_c_r.f  <= f_vec;
      d1_c_r.ok <= ctx_fo.ok && st_f.ok;
      for (int i = 0; i < 3; i++) d1_p_r[i] <= $signed(ctx_fo.u[i]) * $signed(f_vec[i]);
    end
  end

  logic               d2_v_r;
  ctx_t               d2_c_r;
  logic signed [63:0] d2_dot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d2_v_r <= 1'b0;
    else if (en) d2_v_r <= d1_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_c_r   <= d1_c_r;
      d2_dot_r <= d1_p_r[0] + d1_p_r[1] + d1_p_r[2];
    end
  end

  // Round the projection length
  logic                       d3_v_r;
  ctx_t                       d3_c_r;
  logic signed [VW_MID-1:0]   d3_al_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d3_v_r <= 1'b0;
    else if (en) d3_v_r <= d2_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3_c_r  <= d2_c_r;
      d3_al_r <= VW_MID'(shr_round(d2_dot_r, INT_FRAC));
    end
  end

  // Projection along u
  logic               d4_v_r;
  ctx_t               d4_c_r;
  logic signed [63:0] d4_p_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) d4_v_r <= 1'b0;
    else if (en) d4_v_r <= d3_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d4_c_r <= d3_c_r;
      for (int i = 0; i < 3; i++) d4_p_r[i] <= d3_al_r * $signed(d3_c_r.u[i]);
    end
  end

  logic                     d5_v_r;
  ctx_t                     d5_c_r;
  logic signed [VW_MID-1:0] d5_r_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) d5_v_r <= 1'b0;
    else if (en) d5_v_r <= d4_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d5_c_r <= d4_c_r;
      for (int i = 0; i < 3; i++) d5_r_r[i] <= VW_MID'(shr_round(d4_p_r[i], INT_FRAC));
    end
  end

  // Remove the projection from f
  logic                    d6_v_r;
  ctx_t                    d6_c_r;
  logic [2:0][VW_MID-1:0]  d6_fp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d6_v_r <= 1'b0;
    else if (en) d6_v_r <= d5_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d6_c_r <= d5_c_r;
      for (int i = 0; i < 3; i++)
        d6_fp_r[i] <= VW_MID'($signed(d5_c_r.f[i])) - d5_r_r[i];
    end
  end

  // Squared length of the orthogonal part
  logic                   d7_v_r;
  ctx_t                   d7_c_r;
  logic [2:0][VW_MID-1:0] d7_fp_r;
  logic [63:0]            d7_s_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) d7_v_r <= 1'b0;
    else if (en) d7_v_r <= d6_v_r;
  end

  always_ff @(posedge clk) begin
    logic [VW_MID-1:0] m;
    if (en) begin
      d7_c_r  <= d6_c_r;
      d7_fp_r <= d6_fp_r;
      for (int i = 0; i < 3; i++) begin
        m = d6_fp_r[i][VW_MID-1] ? (~d6_fp_r[i] + 1'b1) : d6_fp_r[i];
        d7_s_r[i] <= 64'(m) * 64'(m);
      end
    end
  end

  logic                   d8_v_r;
  ctx_t                   d8_c_r;
  logic [2:0][VW_MID-1:0] d8_fp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d8_v_r <= 1'b0;
    else if (en) d8_v_r <= d7_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d8_c_r.u  <= d7_c_r.u;
      d8_c_r.f  <= d7_c_r.f;
      d8_c_r.ok <= d7_c_r.ok && ((d7_s_r[0] + d7_s_r[1] + d7_s_r[2]) >= SHORT_LIM);
      d8_fp_r   <= d7_fp_r;
    end
  end

  // Normalize the orthogonal forward
  nst_t  st_p;
  uvec_t p_vec;
  ctx_t  ctx_po;

  ofr_norm #(.VW(VW_MID), .SBW($bits(ctx_t))) u_norm_orth (
    .clk, .rst_n, .en,
    .in_valid (d8_v_r),
    .vin      (d8_fp_r),
    .sb_in    (d8_c_r),
    .st       (st_p),
    .uout     (p_vec),
    .sb_out   (ctx_po)
  );

  // Cross product u x f
  logic               c1_v_r;
  ctx_t               c1_c_r;
  logic signed [63:0] c1_p_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) c1_v_r <= 1'b0;
    else if (en) c1_v_r <= st_p.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_c_r.u  <= ctx_po.u;
      c1_c_r.f  <= p_vec;
      c1_c_r.ok <= ctx_po.ok && st_p.ok;
      c1_p_r[0] <= $signed(ctx_po.u[1]) * $signed(p_vec[2]);
      c1_p_r[1] <= $signed(ctx_po.u[2]) * $signed(p_vec[1]);
      c1_p_r[2] <= $signed(ctx_po.u[2]) * $signed(p_vec[0]);
      c1_p_r[3] <= $signed(ctx_po.u[0]) * $signed(p_vec[2]);
      c1_p_r[4] <= $signed(ctx_po.u[0]) * $signed(p_vec[1]);
      c1_p_r[5] <= $signed(ctx_po.u[1]) * $signed(p_vec[0]);
    end
  end

  logic               c2_v_r;
  ctx_t               c2_c_r;
  logic signed [63:0] c2_d_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) c2_v_r <= 1'b0;
    else if (en) c2_v_r <= c1_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_c_r <= c1_c_r;
      for (int i = 0; i < 3; i++) c2_d_r[i] <= c1_p_r[2*i] - c1_p_r[2*i+1];
    end
  end

  logic                   c3_v_r;
  ctx_t                   c3_c_r;
  logic [2:0][VW_MID-1:0] c3_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c3_v_r <= 1'b0;
    else if (en) c3_v_r <= c2_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3_c_r <= c2_c_r;
      for (int i = 0; i < 3; i++) c3_y_r[i] <= VW_MID'(shr_round(c2_d_r[i], INT_FRAC));
    end
  end

  // Squared length of the cross product
  logic                   c4_v_r;
  ctx_t                   c4_c_r;
  logic [2:0][VW_MID-1:0] c4_y_r;
  logic [63:0]            c4_s_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) c4_v_r <= 1'b0;
    else if (en) c4_v_r <= c3_v_r;
  end

  always_ff @(posedge clk) begin
    logic [VW_MID-1:0] m;
    if (en) begin
      c4_c_r <= c3_c_r;
      c4_y_r <= c3_y_r;
      for (int i = 0; i < 3; i++) begin
        m = c3_y_r[i][VW_MID-1] ? (~c3_y_r[i] + 1'b1) : c3_y_r[i];
        c4_s_r[i] <= 64'(m) * 64'(m);
      end
    end
  end

  logic                   c5_v_r;
  ctx_t                   c5_c_r;
  logic [2:0][VW_MID-1:0] c5_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c5_v_r <= 1'b0;
    else if (en) c5_v_r <= c4_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c5_c_r.u  <= c4_c_r.u;
      c5_c_r.f  <= c4_c_r.f;
      c5_c_r.ok <= c4_c_r.ok && ((c4_s_r[0] + c4_s_r[1] + c4_s_r[2]) >= SHORT_LIM);
      c5_y_r    <= c4_y_r;
    end
  end

  // Normalize left
  nst_t  st_y;
  uvec_t y_vec;
  ctx_t  ctx_yo;

  ofr_norm #(.VW(VW_MID), .SBW($bits(ctx_t))) u_norm_left (
    .clk, .rst_n, .en,
    .in_valid (c5_v_r),
    .vin      (c5_y_r),
    .sb_in    (c5_c_r),
    .st       (st_y),
    .uout     (y_vec),
    .sb_out   (ctx_yo)
  );

  // Output register: scale to the result format, zero a degenerate item
  logic                       ok_c;
  logic                       res_r;
  logic [8:0][OUT_W-1:0]      m_r;

  assign ok_c = ctx_yo.ok && st_y.ok;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= st_y.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= ok_c;
      for (int i = 0; i < 3; i++) begin
        m_r[i]     <= ok_c ? to_out(ctx_yo.f[i]) : '0;
        m_r[3 + i] <= ok_c ? to_out(y_vec[i]) : '0;
        m_r[6 + i] <= ok_c ? to_out(ctx_yo.u[i]) : '0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = res_r;
  assign out_fx_sx     = m_r[0];
  assign out_fx_sy     = m_r[1];
  assign out_fx_sz     = m_r[2];
  assign out_ly_sx     = m_r[3];
  assign out_ly_sy     = m_r[4];
  assign out_ly_sz     = m_r[5];
  assign out_uz_sx     = m_r[6];
  assign out_uz_sy     = m_r[7];
  assign out_uz_sz     = m_r[8];

endmodule
